### hdl/sabtb_pkg.sv
// ----------------------------------------------------------------------------
// sabtb_pkg: shared types and constants of the set-associative BTB
// Payload structs, configuration register codes, controller states and the
// random eviction LFSR step function.
// ----------------------------------------------------------------------------
package sabtb_pkg;

  localparam int ADDR_W        = 32;
  localparam int SETS_DEFAULT  = 512;
  localparam int WAYS_DEFAULT  = 4;
  localparam int WAY_IDX_MAX_W = 4;   // enough for up to 16 ways
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 8;
  localparam int TAG_BITS_W    = 6;

  localparam logic [TAG_BITS_W-1:0] TAG_BITS_RESET = 6'd16;
  localparam logic [TAG_BITS_W-1:0] TAG_BITS_MAX   = 6'd32;

  localparam logic [CFG_IDX_W-1:0] REG_TAG_BITS       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACE_RANDOM = 2'd1;

  localparam logic [31:0] LFSR_POLY = 32'h8020_0003;
  localparam logic [31:0] LFSR_SEED = 32'h0000_0001;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] pc;
    logic              taken;
    logic [ADDR_W-1:0] actual_target;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] predicted_target;
    logic              tag_matched;
  } out_item_t;

  typedef struct packed {
    logic                     ready;
    logic [WAY_IDX_MAX_W-1:0] want;
  } lfsr_status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_FIN
  } state_t;

  function automatic logic [31:0] lfsr_step(input logic [31:0] x);
    logic [31:0] y;
    y = x >> 1;
    if (x[0]) begin
      y = y ^ LFSR_POLY;
    end
    return y;
  endfunction

endpackage

### hdl/sabtb_ram.sv
// ----------------------------------------------------------------------------
// sabtb_ram: simple dual-port synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sabtb_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/sabtb_lfsr.sv
// ----------------------------------------------------------------------------
// sabtb_lfsr: random replacement source
// Holds the Galois LFSR and works out, one nibble per cycle, the residue
// modulo the way count of the value the next step will produce.
// ----------------------------------------------------------------------------
module sabtb_lfsr #(
  parameter int WAYS = sabtb_pkg::WAYS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    draw,
  output sabtb_pkg::lfsr_status_t status
);

  logic [31:0] lfsr;
  logic [31:0] nxt;
  logic        busy;
  logic [2:0]  cnt;
  logic [3:0]  res;
  logic [2:0]  nib_idx;
  logic [3:0]  nib;
  logic [3:0]  mod_tbl [256];

  // Residue table of every byte value, fixed at elaboration.
  for (genvar v = 0; v < 256; v++) begin : g_tbl
    assign mod_tbl[v] = 4'(v % WAYS);
  end

  assign nxt     = sabtb_pkg::lfsr_step(lfsr);
  assign nib_idx = 3'(3'd7 - cnt);
  assign nib     = nxt[{nib_idx, 2'b00} +: 4];

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= sabtb_pkg::LFSR_SEED;
      busy <= 1'b1;
      cnt  <= '0;
      res  <= '0;
    end else if (draw) begin
      lfsr <= nxt;
      busy <= 1'b1;
      cnt  <= '0;
      res  <= '0;
    end else if (busy) begin
      // Horner step, most significant nibble first.
      res <= mod_tbl[{res, nib}];
      cnt <= cnt + 3'd1;
      if (cnt == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

  assign status.ready = !busy;
  assign status.want  = res;

endmodule

### hdl/sabtb_way_sel.sv
// ----------------------------------------------------------------------------
// sabtb_way_sel: tag match and hit way selection
// Compares the tag with every way of a set and picks the most recent way
// among those that match.
// ----------------------------------------------------------------------------
module sabtb_way_sel #(
  parameter int WAYS = sabtb_pkg::WAYS_DEFAULT,
  parameter int RW   = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic [WAYS-1:0][sabtb_pkg::ADDR_W-1:0] tags,
  input  logic [WAYS-1:0][RW-1:0]                ranks,
  input  logic [sabtb_pkg::ADDR_W-1:0]           tag,
  output logic [WAYS-1:0]                        sel
);

  logic [WAYS-1:0] match;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = (tags[w] == tag);
    end
    // A matching way wins unless another matching way is more recent.
    for (int w = 0; w < WAYS; w++) begin
      sel[w] = match[w];
      for (int v = 0; v < WAYS; v++) begin
        if (v != w && match[v] && (ranks[v] < ranks[w])) begin
          sel[w] = 1'b0;
        end
      end
    end
  end

endmodule

### hdl/set_assoc_branch_target_buffer.sv
// ----------------------------------------------------------------------------
// set_assoc_branch_target_buffer: set-associative BTB with recency order
// One RAM row per set holds every way's tag, target and recency rank; each
// lookup or update reads the row and selects a way; taken updates write it back.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_data  (in_item_t)
//   out      output     out_valid / out_ready  out_data (out_item_t)
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item passes through the transfer (row read), way select and write back,
// which writes the row only for a taken update. Its result is registered at
// write back, and no new item is taken until write back of the last is done.
// Write back waits while the previous result is still unaccepted in the output
// register. The residue for a random eviction is recomputed after each one, so
// back-to-back random evictions can stall write back until it is ready. After
// reset a clearing pass writes every row, during which no item is taken; cfg
// writes are always taken.
//
module set_assoc_branch_target_buffer #(
  parameter int SETS = sabtb_pkg::SETS_DEFAULT,
  parameter int WAYS = sabtb_pkg::WAYS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  sabtb_pkg::in_item_t                in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output sabtb_pkg::out_item_t               out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sabtb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sabtb_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW    = sabtb_pkg::ADDR_W;
  localparam int IW    = $clog2(SETS);
  localparam int RW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SHIFT = $clog2(SETS + 1) - 1;
  localparam int ROW_W = WAYS * (2 * AW + RW);
  localparam logic [IW-1:0] SET_MASK = IW'(SETS - 1);
  localparam logic [RW-1:0] LRU_RANK = RW'(WAYS - 1);

  sabtb_pkg::state_t       state;
  sabtb_pkg::state_t       state_next;
  sabtb_pkg::in_item_t     item;
  sabtb_pkg::lfsr_status_t lst;

  logic [IW-1:0]                tag_idx_unused_guard;
  logic [IW-1:0]                clr_addr;
  logic [IW-1:0]                set_idx;
  logic [AW-1:0]                tag;
  logic [sabtb_pkg::TAG_BITS_W-1:0] tag_bits;
  logic                         replace_random;
  logic                         hit;
  logic [WAYS-1:0]              hit_oh;

  logic                         accept;
  logic                         fin_go;
  logic                         need_rand;
  logic                         draw;
  logic                         ram_we;
  logic [IW-1:0]                ram_waddr;
  logic [ROW_W-1:0]             ram_wdata;
  logic [ROW_W-1:0]             ram_rdata;
  logic [IW-1:0]                in_idx;
  logic [AW-1:0]                in_tag;
  logic [sabtb_pkg::TAG_BITS_W-1:0] tw_c;
  logic [AW:0]                  tag_keep;

  logic [WAYS-1:0][AW-1:0]      rd_tags;
  logic [WAYS-1:0][AW-1:0]      rd_tgts;
  logic [WAYS-1:0][RW-1:0]      rd_ranks;
  logic [WAYS-1:0][AW-1:0]      wr_tags;
  logic [WAYS-1:0][AW-1:0]      wr_tgts;
  logic [WAYS-1:0][RW-1:0]      wr_ranks;
  logic [WAYS-1:0][RW-1:0]      clr_ranks;
  logic [WAYS-1:0]              sel;
  logic [WAYS-1:0]              vic_oh;
  logic [WAYS-1:0]              chosen;
  logic [RW-1:0]                want;
  logic [RW-1:0]                r_sel;
  logic [AW-1:0]                hit_tgt;

  assign tag_idx_unused_guard = in_idx;

  // Set index and tag of the incoming item.
  assign in_idx   = in_data.pc[IW-1:0] & SET_MASK;
  assign tw_c     = (tag_bits > sabtb_pkg::TAG_BITS_MAX) ? sabtb_pkg::TAG_BITS_MAX
                                                       : tag_bits;
  assign tag_keep = ((AW+1)'(1) << tw_c) - (AW+1)'(1);
  assign in_tag   = (in_data.pc >> SHIFT) & tag_keep[AW-1:0];

  assign rd_tags  = ram_rdata[WAYS*AW-1:0];
  assign rd_tgts  = ram_rdata[2*WAYS*AW-1:WAYS*AW];
  assign rd_ranks = ram_rdata[ROW_W-1:2*WAYS*AW];

  sabtb_ram #(
    .DEPTH(SETS),
    .WIDTH(ROW_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (accept),
    .raddr(tag_idx_unused_guard),
    .rdata(ram_rdata)
  );

  sabtb_way_sel #(
    .WAYS(WAYS),
    .RW  (RW)
  ) u_way_sel (
    .tags (rd_tags),
    .ranks(rd_ranks),
    .tag  (tag),
    .sel  (sel)
  );

  sabtb_lfsr #(
    .WAYS(WAYS)
  ) u_lfsr (
    .clk   (clk),
    .rst   (rst),
    .draw  (draw),
    .status(lst)
  );

  // Victim selection, recency update and new row contents.
  always_comb begin
    want    = replace_random ? lst.want[RW-1:0] : LRU_RANK;
    r_sel   = '0;
    hit_tgt = '0;
    for (int w = 0; w < WAYS; w++) begin
      vic_oh[w]    = (rd_ranks[w] == want);
      clr_ranks[w] = RW'(w);
    end
    chosen = hit ? hit_oh : vic_oh;
    for (int w = 0; w < WAYS; w++) begin
      if (chosen[w]) begin
        r_sel = r_sel | rd_ranks[w];
      end
      if (hit_oh[w]) begin
        hit_tgt = hit_tgt | rd_tgts[w];
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (chosen[w]) begin
        wr_tags[w]  = tag;
        wr_tgts[w]  = item.actual_target;
        wr_ranks[w] = '0;
      end else begin
        wr_tags[w]  = rd_tags[w];
        wr_tgts[w]  = rd_tgts[w];
        wr_ranks[w] = (rd_ranks[w] < r_sel) ? RW'(rd_ranks[w] + RW'(1)) : rd_ranks[w];
      end
    end
  end

  assign need_rand = item.kind && item.taken && !hit && replace_random;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      sabtb_pkg::ST_CLEAR: begin
        if (clr_addr == SET_MASK || clr_addr == IW'(SETS - 1)) begin
          state_next = sabtb_pkg::ST_IDLE;
        end
      end
      sabtb_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = sabtb_pkg::ST_LOOK;
        end
      end
      sabtb_pkg::ST_LOOK: begin
        state_next = sabtb_pkg::ST_FIN;
      end
      sabtb_pkg::ST_FIN: begin
        if (fin_go) begin
          state_next = sabtb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sabtb_pkg::ST_CLEAR;
      end
    endcase
  end

  // Outputs of the controller.
  always_comb begin
    in_ready  = 1'b0;
    fin_go    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = set_idx;
    ram_wdata = {wr_ranks, wr_tgts, wr_tags};
    case (state)
      sabtb_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = {clr_ranks, {(2 * WAYS * AW){1'b0}}};
      end
      sabtb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      sabtb_pkg::ST_LOOK: begin
        in_ready = 1'b0;
      end
      sabtb_pkg::ST_FIN: begin
        fin_go = (!out_valid || out_ready) && (!need_rand || lst.ready);
        ram_we = fin_go && item.kind && item.taken;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign accept    = in_valid && in_ready;
  assign draw      = fin_go && need_rand;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sabtb_pkg::ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == sabtb_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_bits       <= sabtb_pkg::TAG_BITS_RESET;
      replace_random <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        sabtb_pkg::REG_TAG_BITS:       tag_bits       <= cfg_data[sabtb_pkg::TAG_BITS_W-1:0];
        sabtb_pkg::REG_REPLACE_RANDOM: replace_random <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item    <= in_data;
      tag     <= in_tag;
      set_idx <= in_idx;
    end
    if (state == sabtb_pkg::ST_LOOK) begin
      hit    <= |sel;
      hit_oh <= sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_data.predicted_target <= (!item.kind && hit) ? hit_tgt : '0;
      out_data.tag_matched      <= hit;
    end
  end

  // Checks on the controller.
  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == sabtb_pkg::ST_LOOK)
    else $error("item transfer not followed by way selection");

  a_draw_ready: assert property (@(posedge clk) disable iff (rst)
    draw |-> lst.ready)
    else $error("random eviction used an unfinished residue");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == sabtb_pkg::ST_FIN)
    else $error("result appeared outside write back");

  a_one_way_written: assert property (@(posedge clk) disable iff (rst)
    (fin_go && item.kind && item.taken) |-> $onehot(chosen))
    else $error("update did not select exactly one way");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of set_assoc_branch_target_buffer
// Lookups and updates go in through a gap-inserting driver, results are
// checked in order against a behavioral model of the tag store, the targets,
// the per-set recency order and the random eviction LFSR. The run walks
// through several tag widths and both eviction policies.
// ----------------------------------------------------------------------------
module tb;

  localparam int SETS = sabtb_pkg::SETS_DEFAULT;
  localparam int WAYS = sabtb_pkg::WAYS_DEFAULT;
  localparam int IDX_BITS = $clog2(SETS);
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 165;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT = 4000;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;
  localparam logic [sabtb_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [sabtb_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  sabtb_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sabtb_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [sabtb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sabtb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  set_assoc_branch_target_buffer #(
    .SETS(SETS),
    .WAYS(WAYS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Register settings per phase; the first phase runs on the reset values.
  logic [sabtb_pkg::CFG_DATA_W-1:0] width_setting [PHASES] =
    '{8'd16, 8'd0, 8'd32, 8'h3F, 8'd1, 8'hC8, 8'd23, 8'd12};
  logic [sabtb_pkg::CFG_DATA_W-1:0] policy_setting [PHASES] =
    '{8'h00, 8'h00, 8'h01, 8'h01, 8'hFF, 8'hFE, 8'h01, 8'h00};
  logic [IDX_BITS-1:0] set_pool [4] = '{9'h000, 9'h001, 9'h155, 9'h1FF};

  sabtb_pkg::in_item_t pending_items [$];
  sabtb_pkg::out_item_t expected_results [$];

  // Model state of the buffer.
  logic [31:0] btb_tag [SETS][WAYS];
  logic [31:0] btb_target [SETS][WAYS];
  int unsigned btb_rank [SETS][WAYS];
  logic [31:0] evict_lfsr;
  logic [5:0] cfg_tag_bits;
  logic cfg_replace_random;

  int fail_count = 0;
  int results_checked = 0;
  int n_lookups = 0;
  int n_hits = 0;
  int n_taken_updates = 0;
  int n_settings = 1;

  function automatic void promote_way(int unsigned set_i, int unsigned way);
    int unsigned old_rank;
    old_rank = btb_rank[set_i][way];
    for (int w = 0; w < WAYS; w++) begin
      if (btb_rank[set_i][w] < old_rank) begin
        btb_rank[set_i][w] = btb_rank[set_i][w] + 1;
      end
    end
    btb_rank[set_i][way] = 0;
  endfunction

  // Computes the result of one item and applies its effect on the model.
  function automatic sabtb_pkg::out_item_t btb_predict(sabtb_pkg::in_item_t item);
    sabtb_pkg::out_item_t res;
    int unsigned set_i;
    int unsigned width;
    int unsigned want;
    int unsigned victim;
    int unsigned best_rank;
    int hit;
    logic [31:0] mask;
    logic [31:0] tag;
    set_i = item.pc & (SETS - 1);
    width = (cfg_tag_bits > 32) ? 32 : cfg_tag_bits;
    mask = (width == 32) ? 32'hFFFF_FFFF : ((32'h1 << width) - 32'h1);
    tag = (item.pc >> IDX_BITS) & mask;
    hit = -1;
    best_rank = 0;
    // Several ways may hold the same tag; the most recent one wins.
    for (int w = 0; w < WAYS; w++) begin
      if (btb_tag[set_i][w] == tag && (hit < 0 || btb_rank[set_i][w] < best_rank)) begin
        hit = w;
        best_rank = btb_rank[set_i][w];
      end
    end
    res.tag_matched = (hit >= 0);
    res.predicted_target = '0;
    if (item.kind == KIND_LOOKUP) begin
      if (hit >= 0) begin
        res.predicted_target = btb_target[set_i][hit];
      end
    end else if (item.taken) begin
      if (hit >= 0) begin
        btb_target[set_i][hit] = item.actual_target;
        promote_way(set_i, hit);
      end else begin
        want = WAYS - 1;
        if (cfg_replace_random) begin
          evict_lfsr = evict_lfsr[0] ? ((evict_lfsr >> 1) ^ 32'h8020_0003)
                                     : (evict_lfsr >> 1);
          want = evict_lfsr % WAYS;
        end
        victim = 0;
        for (int w = 0; w < WAYS; w++) begin
          if (btb_rank[set_i][w] == want) begin
            victim = w;
          end
        end
        btb_tag[set_i][victim] = tag;
        btb_target[set_i][victim] = item.actual_target;
        promote_way(set_i, victim);
      end
    end
    return res;
  endfunction

  // Driver: one item per transfer, random gaps between items.
  int unsigned feed_gap = 0;
  always @(posedge clk) begin : feeder
    int unsigned roll;
    if (rst) begin
      in_valid <= 1'b0;
      feed_gap <= 0;
    end else if (!(in_valid && !in_ready)) begin
      if (feed_gap != 0) begin
        feed_gap <= feed_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          feed_gap <= 0;
        end else if (roll < 94) begin
          feed_gap <= $urandom_range(1, 3);
        end else begin
          feed_gap <= $urandom_range(8, 40);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off to back the block up.
  int unsigned sink_stall = 0;
  logic hold_done = 1'b0;
  always @(posedge clk) begin : sink
    int unsigned roll;
    if (rst) begin
      out_ready <= 1'b0;
      sink_stall <= 0;
      hold_done <= 1'b0;
    end else if (sink_stall != 0) begin
      sink_stall <= sink_stall - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && results_checked >= 300) begin
      hold_done <= 1'b1;
      sink_stall <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        out_ready <= 1'b1;
      end else if (roll < 95) begin
        out_ready <= 1'b0;
        sink_stall <= $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b0;
        sink_stall <= $urandom_range(8, 40);
      end
    end
  end

  // Scoreboard: tracks register writes, checks results, predicts new items.
  always @(posedge clk) begin : scoreboard
    sabtb_pkg::out_item_t want_out;
    if (rst) begin
      for (int s = 0; s < SETS; s++) begin
        for (int w = 0; w < WAYS; w++) begin
          btb_tag[s][w] = '0;
          btb_target[s][w] = '0;
          btb_rank[s][w] = w;
        end
      end
      evict_lfsr = 32'h1;
      cfg_tag_bits = 6'd16;
      cfg_replace_random = 1'b0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == sabtb_pkg::REG_TAG_BITS) begin
          cfg_tag_bits = cfg_data[5:0];
        end else if (cfg_index == sabtb_pkg::REG_REPLACE_RANDOM) begin
          cfg_replace_random = cfg_data[0];
        end
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: predicted_target %h tag_matched %b",
                 out_data.predicted_target, out_data.tag_matched);
          fail_count++;
        end else begin
          want_out = expected_results.pop_front();
          if (out_data.predicted_target !== want_out.predicted_target) begin
            $error("predicted_target: expected %h, actual %h",
                   want_out.predicted_target, out_data.predicted_target);
            fail_count++;
          end
          if (out_data.tag_matched !== want_out.tag_matched) begin
            $error("tag_matched: expected %b, actual %b",
                   want_out.tag_matched, out_data.tag_matched);
            fail_count++;
          end
        end
        results_checked <= results_checked + 1;
      end
      if (in_valid && in_ready) begin
        want_out = btb_predict(in_data);
        if (in_data.kind == KIND_LOOKUP) begin
          n_lookups++;
          if (want_out.tag_matched) begin
            n_hits++;
          end
        end else if (in_data.taken) begin
          n_taken_updates++;
        end
        expected_results.push_back(want_out);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("[set_assoc_branch_target_buffer] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_item(input logic kind, input logic [31:0] pc, input logic taken,
                          input logic [31:0] target);
    sabtb_pkg::in_item_t item;
    item.kind = kind;
    item.pc = pc;
    item.taken = taken;
    item.actual_target = target;
    pending_items.push_back(item);
  endtask

  // Waits until every item is in and every result is out, then lets the
  // pipeline settle before touching the registers. The check runs on the
  // falling edge so that all rising-edge updates have landed.
  task automatic wait_idle();
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sabtb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sabtb_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [22:0] tag_pool [6];
    sabtb_pkg::in_item_t item;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Every reset entry holds tag 0, so the first lookup matches all ways.
    add_item(KIND_LOOKUP, 32'h0000_0000, 1'b0, 32'hFFFF_FFFF);
    add_item(KIND_UPDATE, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF);
    add_item(KIND_LOOKUP, 32'h0000_0000, 1'b1, 32'h0000_0000);
    add_item(KIND_UPDATE, 32'h0000_0200, 1'b0, 32'h1234_5678);
    add_item(KIND_LOOKUP, 32'h0000_0200, 1'b0, 32'h0000_0000);
    add_item(KIND_UPDATE, 32'h0000_0200, 1'b1, 32'hA5A5_5A5A);
    add_item(KIND_UPDATE, 32'h0000_0400, 1'b1, 32'h5A5A_A5A5);
    add_item(KIND_UPDATE, 32'h0000_0600, 1'b1, 32'h0000_0001);
    add_item(KIND_UPDATE, 32'h0000_0800, 1'b1, 32'h8000_0000);
    add_item(KIND_LOOKUP, 32'h0000_0000, 1'b0, 32'h0000_0000);
    add_item(KIND_LOOKUP, 32'h0000_0200, 1'b0, 32'h0000_0000);
    add_item(KIND_UPDATE, 32'h0000_0200, 1'b1, 32'h0F0F_F0F0);
    add_item(KIND_LOOKUP, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    add_item(KIND_UPDATE, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000);
    add_item(KIND_LOOKUP, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000);
    // PC bits above the tag are outside the compare.
    add_item(KIND_LOOKUP, 32'h01FF_FFFF, 1'b0, 32'h0000_0000);
    add_item(KIND_UPDATE, 32'h01FF_FFFF, 1'b1, 32'hDEAD_BEEF);
    add_item(KIND_LOOKUP, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        write_reg(sabtb_pkg::REG_TAG_BITS, width_setting[p]);
        write_reg(sabtb_pkg::REG_REPLACE_RANDOM, policy_setting[p]);
        // Writes to unmapped indexes must leave both registers alone.
        if (p == 4) begin
          write_reg(REG_SPARE_A, 8'h05);
        end
        if (p == 7) begin
          write_reg(REG_SPARE_B, 8'hFF);
        end
        n_settings++;
      end
      tag_pool[0] = '0;
      tag_pool[1] = '1;
      for (int k = 2; k < 6; k++) begin
        tag_pool[k] = 23'($urandom);
      end
      // Most items hit a few sets with a few tags so that hits, evictions
      // and recency reordering come up often.
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        item.kind = ($urandom_range(0, 99) < 40) ? KIND_LOOKUP : KIND_UPDATE;
        item.taken = ($urandom_range(0, 99) < 80);
        item.actual_target = $urandom;
        if ($urandom_range(0, 99) < 85) begin
          item.pc = {tag_pool[$urandom_range(0, 5)], set_pool[$urandom_range(0, 3)]};
        end else begin
          item.pc = $urandom;
        end
        pending_items.push_back(item);
      end
    end

    wait_idle();
    $display("Checked %0d results over %0d register settings:",
             results_checked, n_settings);
    $display("%0d lookups (%0d hits), %0d taken updates.",
             n_lookups, n_hits, n_taken_updates);
    if (fail_count == 0) begin
      $display("[set_assoc_branch_target_buffer] OK");
    end else begin
      $display("[set_assoc_branch_target_buffer] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/sabtb_pkg.sv
hdl/sabtb_ram.sv
hdl/sabtb_lfsr.sv
hdl/sabtb_way_sel.sv
hdl/set_assoc_branch_target_buffer.sv
tb/tb.sv
